// ----- rtl/ast_pkg.sv -----
`default_nettype none

package ast_pkg;

   // default table depth
   localparam int SLOT_COUNT_DEF = 16;

   // time scale and saturation limits
   localparam int          UNITS_PER_MS = 10000;
   localparam logic [64:0] ROUND_UP     = 65'd9999;
   localparam logic [30:0] COUNT_MAX    = 31'h7fffffff;
   localparam logic [31:0] WAIT_MAX     = 32'hfffffffe;
   localparam logic [31:0] WAIT_NONE    = 32'hffffffff;

   // command codes
   localparam logic [2:0] CMD_TICK     = 3'd0;
   localparam logic [2:0] CMD_ONE_SHOT = 3'd1;
   localparam logic [2:0] CMD_PERIODIC = 3'd2;
   localparam logic [2:0] CMD_DISARM   = 3'd3;
   localparam logic [2:0] CMD_READ     = 3'd4;

   // result kinds
   localparam logic [2:0] KIND_ARM    = 3'd0;
   localparam logic [2:0] KIND_SIGNAL = 3'd1;
   localparam logic [2:0] KIND_WAIT   = 3'd2;
   localparam logic [2:0] KIND_TIME   = 3'd3;
   localparam logic [2:0] KIND_ACK    = 3'd4;

   // status codes
   localparam logic [1:0] STAT_OK      = 2'd0;
   localparam logic [1:0] STAT_INVALID = 2'd1;
   localparam logic [1:0] STAT_FULL    = 2'd2;

   typedef struct packed {
      logic [2:0]         cmd;
      logic [31:0]        elapsed_ms;
      logic signed [63:0] base_time;
      logic signed [63:0] offset_time;
      logic [15:0]        event_id;
      logic [31:0]        target_cookie;
   } ast_req_type;

   typedef struct packed {
      logic [2:0]         kind;
      logic [1:0]         status;
      logic [31:0]        issued_cookie;
      logic [15:0]        signal_event;
      logic [30:0]        signal_count;
      logic signed [63:0] time_value;
      logic [31:0]        wait_ms;
      logic               last;
   } ast_rsp_type;

   // one table entry
   typedef struct packed {
      logic        periodic;
      logic [31:0] cookie;
      logic [15:0] event_id;
      logic [63:0] start;
      logic [63:0] interval;
   } ast_slot_type;

   // divider command and answer
   typedef struct packed {
      logic        start;
      logic [64:0] dividend;
      logic [63:0] divisor;
   } ast_div_req_type;

   typedef struct packed {
      logic        done;
      logic [64:0] quotient;
      logic [63:0] remainder;
   } ast_div_rsp_type;

endpackage

`default_nettype wire

// ----- rtl/alarm_slot_table_timer_unit.sv -----
`default_nettype none

// Alarm slot table timer. A command beat is taken when start is high and busy
// is low; busy stays high until the command's last result is shown and falls
// in that same cycle. Results appear one per cycle at most, each for one
// cycle with rsp_strobe, and cannot be held off. A tick walks the table one
// slot at a time: it skips empty slots, takes the wait of each pending slot
// from a reciprocal multiply with up to three correction steps, and gets the
// period count of each periodic slot that falls due from a single 65-step
// shift-subtract divider.
module alarm_slot_table_timer_unit
   import ast_pkg::*;
#(
   parameter int SLOT_COUNT = SLOT_COUNT_DEF
)(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire ast_req_type req_item,
   output logic             rsp_strobe,
   output ast_rsp_type      rsp_item
);

   localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
   localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(SLOT_COUNT - 1);

   // wait conversion: saturation bound and reciprocal of the ms scale
   localparam logic [63:0] WAIT_LIM = 64'(WAIT_MAX) * 64'(UNITS_PER_MS);
   localparam logic [32:0] W_RECIP  = 33'((66'd1 << 46) / 66'(UNITS_PER_MS));
   localparam logic [16:0] W_STEP   = 17'(UNITS_PER_MS);

   // sequencer states
   localparam logic [4:0] ST_IDLE     = 5'd0;
   localparam logic [4:0] ST_DECODE   = 5'd1;
   localparam logic [4:0] ST_TK_TIME  = 5'd2;
   localparam logic [4:0] ST_SC_READ  = 5'd3;
   localparam logic [4:0] ST_SPAN_SUM = 5'd4;
   localparam logic [4:0] ST_SPAN_DIF = 5'd5;
   localparam logic [4:0] ST_SC_DUE   = 5'd6;
   localparam logic [4:0] ST_SC_PDIV  = 5'd7;
   localparam logic [4:0] ST_SC_WMUL  = 5'd8;
   localparam logic [4:0] ST_SC_WREM  = 5'd9;
   localparam logic [4:0] ST_SC_WFIX  = 5'd10;
   localparam logic [4:0] ST_SC_END   = 5'd11;
   localparam logic [4:0] ST_AR_DUE   = 5'd12;
   localparam logic [4:0] ST_AR_PLACE = 5'd13;
   localparam logic [4:0] ST_AR_REPLY = 5'd14;
   localparam logic [4:0] ST_DS_READ  = 5'd15;
   localparam logic [4:0] ST_DS_CMP   = 5'd16;

   logic [4:0]            state_ff, state_in;
   ast_req_type           req_ff, req_in;
   logic [63:0]           ref_ff, ref_in;
   logic [31:0]           cookie_ff, cookie_in;
   logic [31:0]           ck_ff, ck_in;
   logic [SLOT_COUNT-1:0] valid_ff, valid_in;
   logic [IDX_W-1:0]      idx_ff, idx_in;
   logic                  redo_ff, redo_in;
   logic [31:0]           best_ff, best_in;
   logic signed [64:0]    sum_ff, sum_in;
   logic signed [65:0]    diff_ff, diff_in;
   logic [45:0]           wx_ff, wx_in;
   logic [31:0]           wq_ff, wq_in;
   logic [16:0]           wr_ff, wr_in;
   logic                  rsp_strobe_ff, rsp_strobe_in;
   ast_rsp_type           rsp_ff, rsp_in;

   // slot table memory
   ast_slot_type          mem [SLOT_COUNT];
   ast_slot_type          rd_ff;
   logic                  rd_en;
   logic                  wr_en;
   logic [IDX_W-1:0]      wr_idx;
   ast_slot_type          wr_data;

   ast_div_req_type       div_req;
   ast_div_rsp_type       div_rsp;

   logic                  accept;
   logic                  is_tick;
   logic                  is_due;
   logic                  w_far;
   logic [45:0]           tick_units;
   logic [63:0]           span_a;
   logic [63:0]           span_b;
   logic [IDX_W-1:0]      free_idx;
   logic                  free_found;
   logic                  q_sat_cnt;
   logic [64:0]           w_prod;
   logic [63:0]           new_start;
   logic [30:0]           cnt_val;

   assign accept  = start && (state_ff == ST_IDLE);
   assign busy    = (state_ff != ST_IDLE);
   assign is_tick = (req_ff.cmd == CMD_TICK);
   assign is_due  = diff_ff[65] || (diff_ff == '0);
   assign w_far   = diff_ff[64] || (diff_ff[63:0] > WAIT_LIM);

   assign tick_units = 46'(req_ff.elapsed_ms) * 46'(UNITS_PER_MS);
   assign span_a     = is_tick ? rd_ff.start    : req_ff.base_time;
   assign span_b     = is_tick ? rd_ff.interval : req_ff.offset_time;

   // periodic count and advanced start
   assign q_sat_cnt = (div_rsp.quotient[64:31] != '0);
   assign cnt_val   = q_sat_cnt ? COUNT_MAX : div_rsp.quotient[30:0];
   assign new_start = q_sat_cnt ?
                      rd_ff.start + {rd_ff.interval[32:0], 31'd0} - rd_ff.interval :
                      ref_ff - div_rsp.remainder;

   // quotient estimate for the wait, never above the exact value
   assign w_prod = 65'(wx_ff[45:14]) * 65'(W_RECIP);

   // lowest free slot
   always_comb begin
      free_idx   = '0;
      free_found = 1'b0;
      for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
         if (!valid_ff[i]) begin
            free_idx   = IDX_W'(i);
            free_found = 1'b1;
         end
      end
   end

   // sequencer
   always_comb begin
      state_in      = state_ff;
      req_in        = req_ff;
      ref_in        = ref_ff;
      cookie_in     = cookie_ff;
      ck_in         = ck_ff;
      valid_in      = valid_ff;
      idx_in        = idx_ff;
      redo_in       = redo_ff;
      best_in       = best_ff;
      sum_in        = sum_ff;
      diff_in       = diff_ff;
      wx_in         = wx_ff;
      wq_in         = wq_ff;
      wr_in         = wr_ff;
      rsp_strobe_in = 1'b0;
      rsp_in        = '0;
      rd_en         = 1'b0;
      wr_en         = 1'b0;
      wr_idx        = idx_ff;
      wr_data       = rd_ff;
      div_req       = '0;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               req_in   = req_item;
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            idx_in  = '0;
            redo_in = 1'b0;
            case (req_ff.cmd)
               CMD_TICK: state_in = ST_TK_TIME;
               CMD_ONE_SHOT, CMD_PERIODIC: begin
                  if (req_ff.event_id == '0 ||
                      (req_ff.cmd == CMD_PERIODIC &&
                       (req_ff.offset_time == '0 || req_ff.offset_time[63]))) begin
                     rsp_strobe_in = 1'b1;
                     rsp_in.kind   = KIND_ARM;
                     rsp_in.status = STAT_INVALID;
                     rsp_in.last   = 1'b1;
                     state_in      = ST_IDLE;
                  end else begin
                     ck_in     = cookie_ff;
                     cookie_in = cookie_ff + 32'd1;
                     state_in  = (req_ff.cmd == CMD_PERIODIC) ? ST_AR_PLACE : ST_SPAN_SUM;
                  end
               end
               CMD_DISARM: state_in = ST_DS_READ;
               CMD_READ: begin
                  rsp_strobe_in     = 1'b1;
                  rsp_in.kind       = KIND_TIME;
                  rsp_in.time_value = ref_ff;
                  rsp_in.last       = 1'b1;
                  state_in          = ST_IDLE;
               end
               default: state_in = ST_IDLE;
            endcase
         end
         ST_TK_TIME: begin
            ref_in   = ref_ff + 64'(tick_units);
            best_in  = WAIT_NONE;
            state_in = ST_SC_READ;
         end
         ST_SC_READ: begin
            if (valid_ff[idx_ff]) begin
               rd_en    = 1'b1;
               state_in = ST_SPAN_SUM;
            end else if (idx_ff == IDX_LAST) begin
               state_in = ST_SC_END;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         // exact start + offset - now, in two adds
         ST_SPAN_SUM: begin
            sum_in   = {span_a[63], span_a} + {span_b[63], span_b};
            state_in = ST_SPAN_DIF;
         end
         ST_SPAN_DIF: begin
            diff_in  = {sum_ff[64], sum_ff} - {{2{ref_ff[63]}}, ref_ff};
            state_in = is_tick ? ST_SC_DUE : ST_AR_DUE;
         end
         ST_SC_DUE: begin
            if (is_due && !redo_ff && !rd_ff.periodic) begin
               rsp_strobe_in       = 1'b1;
               rsp_in.kind         = KIND_SIGNAL;
               rsp_in.issued_cookie = rd_ff.cookie;
               rsp_in.signal_event = rd_ff.event_id;
               rsp_in.signal_count = 31'd1;
               valid_in[idx_ff]    = 1'b0;
            end else if (is_due && !redo_ff) begin
               div_req.start    = 1'b1;
               div_req.dividend = {1'b0, ref_ff - rd_ff.start};
               div_req.divisor  = rd_ff.interval;
               state_in         = ST_SC_PDIV;
            end else if (is_due) begin
               best_in = '0;
            end else if (w_far) begin
               if (WAIT_MAX < best_ff) best_in = WAIT_MAX;
            end else begin
               wx_in    = diff_ff[45:0] + ROUND_UP[45:0];
               state_in = ST_SC_WMUL;
            end
            if (!(is_due && !redo_ff && rd_ff.periodic) &&
                !(!is_due && !w_far)) begin
               redo_in = 1'b0;
               if (idx_ff == IDX_LAST) begin
                  state_in = ST_SC_END;
               end else begin
                  idx_in   = idx_ff + 1'b1;
                  state_in = ST_SC_READ;
               end
            end
         end
         ST_SC_PDIV: begin
            if (div_rsp.done) begin
               wr_en                = 1'b1;
               wr_data.start        = new_start;
               rsp_strobe_in        = 1'b1;
               rsp_in.kind          = KIND_SIGNAL;
               rsp_in.issued_cookie = rd_ff.cookie;
               rsp_in.signal_event  = rd_ff.event_id;
               rsp_in.signal_count  = cnt_val;
               redo_in              = 1'b1;
               state_in             = ST_SC_READ;
            end
         end
         // rounded-up wait: estimate, remainder, then a few corrections
         ST_SC_WMUL: begin
            wq_in    = w_prod[63:32];
            state_in = ST_SC_WREM;
         end
         ST_SC_WREM: begin
            wr_in    = 17'(wx_ff - 46'(wq_ff) * 46'(UNITS_PER_MS));
            state_in = ST_SC_WFIX;
         end
         ST_SC_WFIX: begin
            if (wr_ff >= W_STEP) begin
               wr_in = wr_ff - W_STEP;
               wq_in = wq_ff + 32'd1;
            end else begin
               if (wq_ff < best_ff) best_in = wq_ff;
               redo_in = 1'b0;
               if (idx_ff == IDX_LAST) begin
                  state_in = ST_SC_END;
               end else begin
                  idx_in   = idx_ff + 1'b1;
                  state_in = ST_SC_READ;
               end
            end
         end
         ST_SC_END: begin
            rsp_strobe_in  = 1'b1;
            rsp_in.kind    = KIND_WAIT;
            rsp_in.wait_ms = best_ff;
            rsp_in.last    = 1'b1;
            state_in       = ST_IDLE;
         end
         ST_AR_DUE: begin
            if (is_due) begin
               rsp_strobe_in        = 1'b1;
               rsp_in.kind          = KIND_SIGNAL;
               rsp_in.issued_cookie = ck_ff;
               rsp_in.signal_event  = req_ff.event_id;
               rsp_in.signal_count  = 31'd1;
               state_in             = ST_AR_REPLY;
            end else begin
               state_in = ST_AR_PLACE;
            end
         end
         ST_AR_REPLY: begin
            rsp_strobe_in        = 1'b1;
            rsp_in.kind          = KIND_ARM;
            rsp_in.issued_cookie = ck_ff;
            rsp_in.last          = 1'b1;
            state_in             = ST_IDLE;
         end
         ST_AR_PLACE: begin
            rsp_strobe_in        = 1'b1;
            rsp_in.kind          = KIND_ARM;
            rsp_in.issued_cookie = ck_ff;
            rsp_in.last          = 1'b1;
            if (free_found) begin
               wr_en              = 1'b1;
               wr_idx             = free_idx;
               wr_data.periodic   = (req_ff.cmd == CMD_PERIODIC);
               wr_data.cookie     = ck_ff;
               wr_data.event_id   = req_ff.event_id;
               wr_data.start      = req_ff.base_time;
               wr_data.interval   = req_ff.offset_time;
               valid_in[free_idx] = 1'b1;
               rsp_in.status      = STAT_OK;
            end else begin
               rsp_in.status = STAT_FULL;
            end
            state_in = ST_IDLE;
         end
         ST_DS_READ: begin
            if (valid_ff[idx_ff]) begin
               rd_en    = 1'b1;
               state_in = ST_DS_CMP;
            end else if (idx_ff == IDX_LAST) begin
               rsp_strobe_in = 1'b1;
               rsp_in.kind   = KIND_ACK;
               rsp_in.last   = 1'b1;
               state_in      = ST_IDLE;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         ST_DS_CMP: begin
            if (rd_ff.cookie == req_ff.target_cookie || idx_ff == IDX_LAST) begin
               if (rd_ff.cookie == req_ff.target_cookie) valid_in[idx_ff] = 1'b0;
               rsp_strobe_in = 1'b1;
               rsp_in.kind   = KIND_ACK;
               rsp_in.last   = 1'b1;
               state_in      = ST_IDLE;
            end else begin
               idx_in   = idx_ff + 1'b1;
               state_in = ST_DS_READ;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // slot table: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_idx] <= wr_data;
      if (rd_en) rd_ff <= mem[idx_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         ref_ff        <= '0;
         cookie_ff     <= 32'd1;
         valid_ff      <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         ref_ff        <= ref_in;
         cookie_ff     <= cookie_in;
         valid_ff      <= valid_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
      req_ff  <= req_in;
      ck_ff   <= ck_in;
      idx_ff  <= idx_in;
      redo_ff <= redo_in;
      best_ff <= best_in;
      sum_ff  <= sum_in;
      diff_ff <= diff_in;
      wx_ff   <= wx_in;
      wq_ff   <= wq_in;
      wr_ff   <= wr_in;
      rsp_ff  <= rsp_in;
   end

   ast_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_item   = rsp_ff;

   // a result beat only follows a cycle of work
   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(busy))
      else $error("result beat without a command in progress");

   // the cycle after a command is taken shows no result
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> !rsp_strobe)
      else $error("result beat right after command accept");

   // the divider answers only while the sequencer waits for it
   assert property (@(posedge clock) disable iff (reset)
      div_rsp.done |-> (state_ff == ST_SC_PDIV))
      else $error("divider answer outside the divide state");

endmodule

`default_nettype wire

// ----- rtl/ast_div.sv -----
`default_nettype none

module ast_div
   import ast_pkg::*;
(
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire ast_div_req_type div_req,
   output ast_div_rsp_type      div_rsp
);

   localparam int          QBITS = 65;
   localparam logic [6:0]  LAST_STEP = 7'(QBITS - 1);

   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [6:0]  step_ff, step_in;
   logic [64:0] quo_ff, quo_in;
   logic [63:0] rem_ff, rem_in;
   logic [63:0] dsr_ff, dsr_in;
   logic [64:0] trial;
   logic [64:0] trial_sub;

   // restoring division, one quotient bit per cycle
   always_comb begin
      busy_in   = busy_ff;
      done_in   = 1'b0;
      step_in   = step_ff;
      quo_in    = quo_ff;
      rem_in    = rem_ff;
      dsr_in    = dsr_ff;
      trial     = {rem_ff, quo_ff[64]};
      trial_sub = trial - {1'b0, dsr_ff};
      if (div_req.start) begin
         busy_in = 1'b1;
         step_in = '0;
         quo_in  = div_req.dividend;
         rem_in  = '0;
         dsr_in  = div_req.divisor;
      end else if (busy_ff) begin
         if (trial >= {1'b0, dsr_ff}) begin
            rem_in = trial_sub[63:0];
            quo_in = {quo_ff[63:0], 1'b1};
         end else begin
            rem_in = trial[63:0];
            quo_in = {quo_ff[63:0], 1'b0};
         end
         step_in = step_ff + 7'd1;
         if (step_ff == LAST_STEP) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

   assign div_rsp.done      = done_ff;
   assign div_rsp.quotient  = quo_ff;
   assign div_rsp.remainder = rem_ff;

endmodule

`default_nettype wire
